// File: hw/rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and helpers shared by the Base64 encoder modules.
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam int CHAR_W    = 8;
   localparam int SYM_W     = 6;
   localparam int TBL_DEPTH = 64;
   localparam int TBL_AW    = 6;
   localparam int GRP_CHARS = 4;

   // input opcodes
   localparam logic OPC_BYTE  = 1'b0;
   localparam logic OPC_TABLE = 1'b1;

   // reset value of the pad register ('=')
   localparam logic [CHAR_W-1:0] PAD_RESET = 8'd61;

   // standard alphabet anchors
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'd43;
   localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'd47;

   typedef enum logic {
      JOB_GROUP,
      JOB_WRITE
   } job_op_type;

   typedef struct packed {
      logic              opcode;
      logic [CHAR_W-1:0] data_byte;
      logic              end_of_message;
      logic [TBL_AW-1:0] table_index;
      logic [CHAR_W-1:0] table_char;
   } req_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              group_end;
      logic              message_end;
   } rsp_item_type;

   // one unit of work for the emitter: a four-character group or a table write
   typedef struct packed {
      job_op_type                        op;
      logic [GRP_CHARS-1:0][SYM_W-1:0]   sym;
      logic [1:0]                        npad;
      logic                              eom;
      logic [TBL_AW-1:0]                 tbl_idx;
      logic [CHAR_W-1:0]                 tbl_char;
   } job_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [TBL_AW-1:0] addr;
      logic [CHAR_W-1:0] wr_data;
   } tbl_req_type;

   // standard A-Z a-z 0-9 + / alphabet
   function automatic logic [CHAR_W-1:0] std_char(input logic [TBL_AW-1:0] idx);
      logic [CHAR_W-1:0] ext;
      logic [CHAR_W-1:0] res;
      ext = {{(CHAR_W-TBL_AW){1'b0}}, idx};
      if (idx < 6'd26)
         res = CHAR_UPPER_A + ext;
      else if (idx < 6'd52)
         res = CHAR_LOWER_A + ext - 8'd26;
      else if (idx < 6'd62)
         res = CHAR_ZERO + ext - 8'd52;
      else if (idx == 6'd62)
         res = CHAR_PLUS;
      else
         res = CHAR_SLASH;
      return res;
   endfunction

   // true when character slot k of a group is filled with the pad character
   function automatic logic slot_is_pad(input logic [1:0] k, input logic [1:0] npad);
      return ((k == 2'd3) && (npad != 2'd0)) || ((k == 2'd2) && (npad == 2'd2));
   endfunction

endpackage

// File: hw/rtl/b64e_ram.sv
// ----------------------------------------------------------------------------
// b64e_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module b64e_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/b64e_table.sv
// ----------------------------------------------------------------------------
// b64e_table
// Alphabet store: RAM plus per-entry written flags; unwritten entries
// read as the standard alphabet.
// ----------------------------------------------------------------------------
module b64e_table (
   input  logic                        clock,
   input  logic                        reset,
   input  b64e_pkg::tbl_req_type       tbl_req,
   output logic [b64e_pkg::CHAR_W-1:0] tbl_rdata
);
   import b64e_pkg::*;

   logic [TBL_DEPTH-1:0] written_ff;
   logic [TBL_DEPTH-1:0] written_in;
   logic                 rd_written_ff;
   logic [CHAR_W-1:0]    rd_default_ff;
   logic [CHAR_W-1:0]    ram_rdata;

   b64e_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (TBL_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (tbl_req.wr_en),
      .wr_addr (tbl_req.addr),
      .wr_data (tbl_req.wr_data),
      .rd_en   (tbl_req.rd_en),
      .rd_addr (tbl_req.addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      written_in = written_ff;
      if (tbl_req.wr_en) begin
         written_in[tbl_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   // capture flag and default alongside the RAM read
   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         rd_written_ff <= written_ff[tbl_req.addr];
         rd_default_ff <= std_char(tbl_req.addr);
      end
   end

   assign tbl_rdata = rd_written_ff ? ram_rdata : rd_default_ff;

endmodule

// File: hw/rtl/b64e_emit.sv
// ----------------------------------------------------------------------------
// b64e_emit
// Job sequencer: walks a group through the alphabet store one character a
// cycle unless stalled, or does a table write, and drives the result register.
// ----------------------------------------------------------------------------
module b64e_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  b64e_pkg::job_type           job,
   output logic                        job_take,
   input  logic [b64e_pkg::CHAR_W-1:0] pad_char,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output b64e_pkg::rsp_item_type      rsp_data
);
   import b64e_pkg::*;

   // current job
   logic         cur_valid_ff, cur_valid_in;
   job_type      cur_ff, cur_in;
   logic [1:0]   cnt_ff, cnt_in;

   // read stage, table data arrives here
   logic         r_valid_ff, r_valid_in;
   logic         r_pad_ff, r_ge_ff, r_me_ff;

   // result register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_data_ff;

   logic         out_free, r_adv, r_free;
   logic         issue, last, do_write, seq_free, slot_pad;
   tbl_req_type  tbl_req;
   logic [CHAR_W-1:0] tbl_rdata;

   b64e_table u_table (
      .clock     (clock),
      .reset     (reset),
      .tbl_req   (tbl_req),
      .tbl_rdata (tbl_rdata)
   );

   always_comb begin
      out_free = !out_valid_ff || !rsp_stall;
      r_adv    = r_valid_ff && out_free;
      r_free   = !r_valid_ff || r_adv;
      slot_pad = slot_is_pad(cnt_ff, cur_ff.npad);
      issue    = cur_valid_ff && (cur_ff.op == JOB_GROUP) && r_free;
      last     = issue && (cnt_ff == 2'd3);
      do_write = cur_valid_ff && (cur_ff.op == JOB_WRITE);
      seq_free = !cur_valid_ff || last || do_write;
      job_take = job_valid && seq_free;
   end

   always_comb begin
      tbl_req.rd_en   = issue && !slot_pad;
      tbl_req.wr_en   = do_write;
      tbl_req.addr    = do_write ? cur_ff.tbl_idx : cur_ff.sym[cnt_ff];
      tbl_req.wr_data = cur_ff.tbl_char;
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      cnt_in       = cnt_ff;
      if (job_take) begin
         cur_in       = job;
         cur_valid_in = 1'b1;
         cnt_in       = 2'd0;
      end else begin
         if (seq_free) begin
            cur_valid_in = 1'b0;
         end
         if (issue) begin
            cnt_in = cnt_ff + 2'd1;
         end
      end
      r_valid_in = issue || (r_valid_ff && !r_adv);
      out_valid_in = r_adv || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cnt_ff       <= 2'd0;
         r_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         cnt_ff       <= cnt_in;
         r_valid_ff   <= r_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (issue) begin
         r_pad_ff <= slot_pad;
         r_ge_ff  <= (cnt_ff == 2'd3);
         r_me_ff  <= (cnt_ff == 2'd3) && cur_ff.eom;
      end
      if (r_adv) begin
         out_data_ff.out_char    <= r_pad_ff ? pad_char : tbl_rdata;
         out_data_ff.group_end   <= r_ge_ff;
         out_data_ff.message_end <= r_me_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: hw/rtl/base64_encoder_custom_alphabet_unit.sv
// Path: a group-completing or final byte queues a job; the emitter issues
//   each character through its read stage into the result register.
// Throughput: one character per cycle unless the output stalls, set by the
//   single alphabet read port; a group has four characters, pads included.
// Reset (synchronous): drops buffered bytes and queued work, restores the
//   standard alphabet and the '=' pad.
// ----------------------------------------------------------------------------
// base64_encoder_custom_alphabet_unit
// Streaming Base64 encoder with a writable 64-entry alphabet and pad register.
// ----------------------------------------------------------------------------
module base64_encoder_custom_alphabet_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  b64e_pkg::req_item_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output b64e_pkg::rsp_item_type      rsp_data,
   input  logic                        csr_we,
   input  logic [b64e_pkg::CHAR_W-1:0] csr_wdata
);
   import b64e_pkg::*;

   // pad register
   logic [CHAR_W-1:0] pad_char_ff;

   // bytes waiting for the rest of their group; the later byte sits low
   logic [2*CHAR_W-1:0] pend_bytes_ff, pend_bytes_in;
   logic [1:0]          pend_cnt_ff, pend_cnt_in;

   // one-deep job queue in front of the emitter
   logic    job_valid_ff, job_valid_in;
   job_type job_ff;
   job_type new_job;
   logic    make_job;
   logic    job_take;
   logic    accept;

   logic [CHAR_W-1:0] b1, b2, c;

   // Stall only while the queue is full and the emitter is not draining it.
   assign req_stall = job_valid_ff && !job_take;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_char_ff <= PAD_RESET;
      end else if (csr_we) begin
         pad_char_ff <= csr_wdata;
      end
   end

   // Build the job an accepted item launches, if any.
   always_comb begin
      b1 = pend_bytes_ff[2*CHAR_W-1:CHAR_W];
      b2 = pend_bytes_ff[CHAR_W-1:0];
      c  = req_data.data_byte;

      new_job          = '0;
      new_job.tbl_idx  = req_data.table_index;
      new_job.tbl_char = req_data.table_char;
      new_job.eom      = req_data.end_of_message;
      make_job         = 1'b0;
      pend_bytes_in    = pend_bytes_ff;
      pend_cnt_in      = pend_cnt_ff;

      if (req_data.opcode == OPC_TABLE) begin
         // table write: keep buffered bytes, queue the write in order
         new_job.op = JOB_WRITE;
         make_job   = 1'b1;
      end else begin
         new_job.op = JOB_GROUP;
         case (pend_cnt_ff)
            2'd2: begin
               // third byte completes a full group
               new_job.sym[0] = b1[7:2];
               new_job.sym[1] = {b1[1:0], b2[7:4]};
               new_job.sym[2] = {b2[3:0], c[7:6]};
               new_job.sym[3] = c[5:0];
               new_job.npad   = 2'd0;
               make_job       = 1'b1;
               pend_bytes_in  = '0;
               pend_cnt_in    = 2'd0;
            end
            2'd1: begin
               if (req_data.end_of_message) begin
                  // two bytes: three characters plus one pad
                  new_job.sym[0] = b2[7:2];
                  new_job.sym[1] = {b2[1:0], c[7:4]};
                  new_job.sym[2] = {c[3:0], 2'b00};
                  new_job.npad   = 2'd1;
                  make_job       = 1'b1;
                  pend_bytes_in  = '0;
                  pend_cnt_in    = 2'd0;
               end else begin
                  pend_bytes_in = {b2, c};
                  pend_cnt_in   = 2'd2;
               end
            end
            2'd0: begin
               if (req_data.end_of_message) begin
                  // single byte: two characters plus two pads
                  new_job.sym[0] = c[7:2];
                  new_job.sym[1] = {c[1:0], 4'b0000};
                  new_job.npad   = 2'd2;
                  make_job       = 1'b1;
                  pend_bytes_in  = '0;
                  pend_cnt_in    = 2'd0;
               end else begin
                  pend_bytes_in = {b2, c};
                  pend_cnt_in   = 2'd1;
               end
            end
            default: begin
               pend_bytes_in = '0;
               pend_cnt_in   = 2'd0;
            end
         endcase
      end

      job_valid_in = (accept && make_job) || (job_valid_ff && !job_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bytes_ff <= '0;
         pend_cnt_ff   <= 2'd0;
         job_valid_ff  <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         if (accept) begin
            pend_bytes_ff <= pend_bytes_in;
            pend_cnt_ff   <= pend_cnt_in;
         end
      end
   end

   // hold the queued job until the emitter takes it
   always_ff @(posedge clock) begin
      if (accept && make_job) begin
         job_ff <= new_job;
      end
   end

   b64e_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid_ff),
      .job       (job_ff),
      .job_take  (job_take),
      .pad_char  (pad_char_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hw/rtl/b64e_chk.sv
// ----------------------------------------------------------------------------
// b64e_chk
// Port-level checks on the encoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module b64e_chk (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input b64e_pkg::rsp_item_type rsp_data
);
   import b64e_pkg::*;

   logic [1:0] slot_ff;

   // position of the next result inside its four-character group
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 2'd0;
      end else if (rsp_valid && !rsp_stall) begin
         slot_ff <= slot_ff + 2'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_group_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.group_end == (slot_ff == 2'd3)))
      else $error("group_end not on every fourth item");

   a_msg_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.message_end |-> rsp_data.group_end)
      else $error("message_end outside a group's last item");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("busy right after reset");

endmodule

bind base64_encoder_custom_alphabet_unit b64e_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
